>>> rtl/core/tcp_option_address_extractor_unit_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the tcp option address extractor
// ----------------------------------------------------------------------------
`ifndef TCP_OPTION_ADDRESS_EXTRACTOR_UNIT_DEFINES_SVH
`define TCP_OPTION_ADDRESS_EXTRACTOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TOAX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TOAX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/toax_pkg.sv
// ----------------------------------------------------------------------------
// toax_pkg
// types and constants of the tcp option address extractor
// ----------------------------------------------------------------------------
package toax_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 8;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_OPTION_KIND = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_OPTION_SIZE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_VERSION     = 2'd2;

	// configuration reset values
	localparam logic [7:0] RST_OPTION_KIND = 8'd254;
	localparam logic [5:0] RST_OPTION_SIZE = 6'd7;
	localparam logic [7:0] RST_VERSION     = 8'd1;

	// input item kinds
	localparam logic ITEM_START = 1'b0;
	localparam logic ITEM_BYTE  = 1'b1;

	// tcp option kinds handled directly
	localparam logic [7:0] OPT_END_OF_LIST = 8'd0;
	localparam logic [7:0] OPT_NO_OP       = 8'd1;

	// smallest size accepted for a candidate; version and address need 7
	localparam logic [5:0] MIN_ADDR_SIZE = 6'd6;
	// fixed tcp header bytes
	localparam logic [5:0] BASE_HDR_BYTES = 6'd20;
	localparam logic [3:0] BASE_HDR_WORDS = 4'd5;
	// body index of the last address byte
	localparam logic [2:0] LAST_ADDR_INDEX = 3'd4;

	typedef enum logic [2:0] {
		STOP_EXHAUSTED = 3'd0,
		STOP_EOL       = 3'd1,
		STOP_SHORT     = 3'd2,
		STOP_OVERRUN   = 3'd3,
		STOP_FOUND     = 3'd4
	} stop_t;

endpackage

>>> rtl/core/tcp_option_address_extractor_unit.sv
// ----------------------------------------------------------------------------
// tcp_option_address_extractor_unit
// Scans the option area of a tcp segment for the option carrying a client
// ipv4 address. The input channel (in_valid / in_stall) moves one item per
// transfer: a start item with header_words opens a segment, then option
// bytes follow one per transfer. The output channel (out_valid / out_stall)
// gives one result per segment: found, client_address and stop_reason, on
// the item that ends the walk; bytes after it are dropped until the next
// start. An item is registered on transfer and evaluated into the result
// register once that register is free, so each result passes through the
// input register and then the result register. One item per cycle is
// sustained while no result waits on out_stall; else the input register
// takes one more item and in_stall then rises until the result leaves.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant for idle periods. Reset clears the walk to idle, empties both
// registers and restores the configuration defaults.
// ----------------------------------------------------------------------------
`include "tcp_option_address_extractor_unit_defines.svh"

module tcp_option_address_extractor_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [toax_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [toax_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               kind,
	input  logic [3:0]                         header_words,
	input  logic [7:0]                         option_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               found,
	output logic [31:0]                        client_address,
	output logic [2:0]                         stop_reason
);

	typedef enum logic [1:0] {
		PH_DONE,
		PH_KIND,
		PH_LEN,
		PH_BODY
	} phase_t;

	// configuration
	logic [7:0] cfg_kind_q;
	logic [5:0] cfg_size_q;
	logic [7:0] cfg_version_q;

	// input register
	logic       valid_s1;
	logic       kind_s1;
	logic [3:0] header_words_s1;
	logic [7:0] option_byte_s1;

	// walk state
	phase_t      phase_q;
	logic [5:0]  bytes_left_q;
	logic [7:0]  current_kind_q;
	logic [5:0]  body_left_q;
	logic [2:0]  body_index_q;
	logic        candidate_q;
	logic [31:0] shift_q;

	phase_t      phase_d;
	logic [5:0]  bytes_left_d;
	logic [7:0]  current_kind_d;
	logic [5:0]  body_left_d;
	logic [2:0]  body_index_d;
	logic        candidate_d;
	logic [31:0] shift_d;

	logic            res_valid;
	toax_pkg::stop_t res_reason;
	logic            addr_hit;

	// result register
	logic            out_valid_q;
	logic            found_q;
	logic [31:0]     address_q;
	toax_pkg::stop_t stop_q;

	logic process;
	logic in_xfer;

	// the held item is evaluated once the result register is free
	assign process  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !process;
	assign in_xfer  = in_valid && !in_stall;

	always_comb begin
		phase_d        = phase_q;
		bytes_left_d   = bytes_left_q;
		current_kind_d = current_kind_q;
		body_left_d    = body_left_q;
		body_index_d   = body_index_q;
		candidate_d    = candidate_q;
		shift_d        = shift_q;
		res_valid      = 1'b0;
		res_reason     = toax_pkg::STOP_EXHAUSTED;
		addr_hit       = 1'b0;
		if (kind_s1 == toax_pkg::ITEM_START) begin
			current_kind_d = '0;
			body_left_d    = '0;
			body_index_d   = '0;
			candidate_d    = 1'b0;
			shift_d        = '0;
			bytes_left_d   = (header_words_s1 > toax_pkg::BASE_HDR_WORDS)
				? ({header_words_s1, 2'b00} - toax_pkg::BASE_HDR_BYTES) : 6'd0;
			if (bytes_left_d == 6'd0) begin
				res_valid = 1'b1;
				phase_d   = PH_DONE;
			end else begin
				phase_d = PH_KIND;
			end
		end else begin
			case (phase_q)
				PH_KIND: begin
					if (option_byte_s1 == toax_pkg::OPT_END_OF_LIST) begin
						res_valid  = 1'b1;
						res_reason = toax_pkg::STOP_EOL;
						phase_d    = PH_DONE;
					end else if (option_byte_s1 == toax_pkg::OPT_NO_OP) begin
						bytes_left_d = bytes_left_q - 6'd1;
						if (bytes_left_d == 6'd0) begin
							res_valid = 1'b1;
							phase_d   = PH_DONE;
						end
					end else if (bytes_left_q <= 6'd1) begin
						// lone kind byte at the end of the area
						res_valid  = 1'b1;
						res_reason = toax_pkg::STOP_OVERRUN;
						phase_d    = PH_DONE;
					end else begin
						current_kind_d = option_byte_s1;
						phase_d        = PH_LEN;
					end
				end
				PH_LEN: begin
					if (option_byte_s1 < 8'd2) begin
						res_valid  = 1'b1;
						res_reason = toax_pkg::STOP_SHORT;
						phase_d    = PH_DONE;
					end else if (option_byte_s1 > {2'b00, bytes_left_q}) begin
						res_valid  = 1'b1;
						res_reason = toax_pkg::STOP_OVERRUN;
						phase_d    = PH_DONE;
					end else begin
						bytes_left_d = bytes_left_q - option_byte_s1[5:0];
						body_left_d  = option_byte_s1[5:0] - 6'd2;
						body_index_d = '0;
						shift_d      = '0;
						candidate_d  = (current_kind_q == cfg_kind_q)
							&& (option_byte_s1 == {2'b00, cfg_size_q})
							&& (cfg_size_q >= toax_pkg::MIN_ADDR_SIZE);
						if (body_left_d != 6'd0) begin
							phase_d = PH_BODY;
						end else if (bytes_left_d == 6'd0) begin
							res_valid = 1'b1;
							phase_d   = PH_DONE;
						end else begin
							phase_d = PH_KIND;
						end
					end
				end
				PH_BODY: begin
					if (candidate_q) begin
						if (body_index_q == 3'd0) begin
							if (option_byte_s1 != cfg_version_q) begin
								candidate_d = 1'b0;
							end
						end else begin
							shift_d = {shift_q[23:0], option_byte_s1};
							addr_hit = (body_index_q == toax_pkg::LAST_ADDR_INDEX);
						end
					end
					if (addr_hit) begin
						res_valid  = 1'b1;
						res_reason = toax_pkg::STOP_FOUND;
						phase_d    = PH_DONE;
					end else begin
						// the index only matters while the option still matches
						if (candidate_q) begin
							body_index_d = body_index_q + 3'd1;
						end
						body_left_d = body_left_q - 6'd1;
						if (body_left_d == 6'd0) begin
							if (bytes_left_q == 6'd0) begin
								res_valid = 1'b1;
								phase_d   = PH_DONE;
							end else begin
								phase_d = PH_KIND;
							end
						end
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_kind_q      <= toax_pkg::RST_OPTION_KIND;
			cfg_size_q      <= toax_pkg::RST_OPTION_SIZE;
			cfg_version_q   <= toax_pkg::RST_VERSION;
			valid_s1        <= 1'b0;
			kind_s1         <= toax_pkg::ITEM_BYTE;
			header_words_s1 <= '0;
			option_byte_s1  <= '0;
			phase_q         <= PH_DONE;
			bytes_left_q    <= '0;
			current_kind_q  <= '0;
			body_left_q     <= '0;
			body_index_q    <= '0;
			candidate_q     <= 1'b0;
			shift_q         <= '0;
			out_valid_q     <= 1'b0;
			found_q         <= 1'b0;
			address_q       <= '0;
			stop_q          <= toax_pkg::STOP_EXHAUSTED;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					toax_pkg::CFG_OPTION_KIND: cfg_kind_q    <= cfg_data;
					toax_pkg::CFG_OPTION_SIZE: cfg_size_q    <= cfg_data[5:0];
					toax_pkg::CFG_VERSION:     cfg_version_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (in_xfer) begin
				valid_s1        <= 1'b1;
				kind_s1         <= kind;
				header_words_s1 <= header_words;
				option_byte_s1  <= option_byte;
			end else if (process) begin
				valid_s1 <= 1'b0;
			end

			if (process) begin
				phase_q        <= phase_d;
				bytes_left_q   <= bytes_left_d;
				current_kind_q <= current_kind_d;
				body_left_q    <= body_left_d;
				body_index_q   <= body_index_d;
				candidate_q    <= candidate_d;
				shift_q        <= shift_d;
			end

			if (process && res_valid) begin
				out_valid_q <= 1'b1;
				found_q     <= addr_hit;
				address_q   <= addr_hit ? shift_d : 32'd0;
				stop_q      <= res_reason;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign client_address = address_q;
	assign stop_reason    = stop_q;

	`TOAX_ASSERT_NOW(a_found_reason, out_valid_q,
		found_q == (stop_q == toax_pkg::STOP_FOUND), "found disagrees with stop reason")
	`TOAX_ASSERT_NOW(a_miss_zero_addr, out_valid_q && !found_q,
		address_q == 32'd0, "address not cleared on a miss")
	`TOAX_ASSERT_NOW(a_kind_has_bytes, phase_q == PH_KIND,
		bytes_left_q != 6'd0, "waiting for a kind byte with an empty area")
	`TOAX_ASSERT_NOW(a_body_index, (phase_q == PH_BODY) && candidate_q,
		(body_left_q != 6'd0) && (body_index_q < toax_pkg::LAST_ADDR_INDEX + 3'd1),
		"body walk out of range")

endmodule
